FILE: hw/rtl/monte_carlo_call_payoff_accumulator_defines.svh
// assertion macros shared by the payoff accumulator modules
`ifndef MONTE_CARLO_CALL_PAYOFF_ACCUMULATOR_DEFINES_SVH
`define MONTE_CARLO_CALL_PAYOFF_ACCUMULATOR_DEFINES_SVH

// same-cycle implication, checked out of reset
`define MCPA_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define MCPA_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/mcpa_pkg.sv
// shared constants and types of the call payoff accumulator
package mcpa_pkg;

    localparam int COUNT_BITS = 32;
    localparam int SUM_BITS   = 64;
    localparam int Q_DEPTH    = 2;
    localparam int SQ_STEPS   = 8;
    localparam int DIV_STEPS  = SUM_BITS;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [31:0] ONE_Q30   = 32'd1073741824;
    // reciprocal of six for values below 64
    localparam logic [5:0]  RECIP6    = 6'd43;

    // configuration register indexes
    localparam logic [1:0] REG_GROWTH   = 2'd0;
    localparam logic [1:0] REG_SPREAD   = 2'd1;
    localparam logic [1:0] REG_STRIKE   = 2'd2;
    localparam logic [1:0] REG_DISCOUNT = 2'd3;

    typedef struct packed {
        logic [31:0] growth;
        logic [15:0] spread;
        logic [31:0] strike;
    } t_front_cfg;

    // one finished run handed from front to back
    typedef struct packed {
        logic [SUM_BITS-1:0]   sum;
        logic [COUNT_BITS-1:0] count;
    } t_run;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_SCALE,
        BK_HOLD
    } t_back_state;

endpackage

FILE: hw/rtl/mcpa_front.sv
// front: terminal price pipeline, payoff accumulation and run hand-off
module mcpa_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  mcpa_pkg::t_front_cfg i_cfg,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic [15:0]         i_sample,
    input  logic                i_last,
    input  logic                i_q_full,
    output logic                o_push,
    output mcpa_pkg::t_run      o_run
);
    import mcpa_pkg::*;

    localparam int NSTG = 19;
    localparam int ST_D = 3;
    localparam int ST_P = 16;

    logic                   en;
    logic [NSTG-1:0]        r_vld;
    logic [NSTG-1:0]        r_last;
    logic signed [10:0]     r_n [ST_D:ST_P];

    logic [15:0]            r_a_z;
    logic [31:0]            r_b_x;
    logic                   r_b_neg;
    logic [32:0]            r_c_ymag;
    logic                   r_c_neg;
    logic [23:0]            r_d_f;
    logic [21:0]            r_e_a;
    logic [21:0]            r_f_a;
    logic [13:0]            r_f_a2;
    logic [21:0]            r_g_a;
    logic [13:0]            r_g_a2;
    logic [5:0]             r_g_a3;
    logic [31:0]            r_h_m;
    logic [31:0]            r_sq [SQ_STEPS];
    logic [63:0]            r_p_prod;
    logic [31:0]            r_q_price;
    logic [31:0]            r_r_pay;
    logic [SUM_BITS-1:0]    r_sum;
    logic [COUNT_BITS-1:0]  r_count;

    logic [15:0]            zmag;
    logic [62:0]            ymul;
    logic [8:0]             q;
    logic [23:0]            rem;
    logic signed [10:0]     n_n;
    logic [23:0]            n_f;
    logic [53:0]            rmul;
    logic [43:0]            a2mul;
    logic [35:0]            a3mul;
    logic [11:0]            a3div;
    logic [31:0]            n_m;
    logic [31:0]            n_price;
    logic [SUM_BITS:0]      sum_ext;
    logic [SUM_BITS-1:0]    n_sum;
    logic [COUNT_BITS-1:0]  n_count;

    // whole pipeline moves unless a closing run finds the queue full
    assign en      = !(r_vld[NSTG-1] && r_last[NSTG-1] && i_q_full);
    assign o_ready = en;

    // valid and last travel along every stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_last <= {r_last[NSTG-2:0], i_last};
        end
    end

    // magnitude of the draw and spread product
    assign zmag = r_a_z[15] ? 16'(-r_a_z) : r_a_z;
    assign ymul = 63'(r_b_x) * 63'(LOG2E_Q30);

    // split y into integer and fraction with floor semantics
    always_comb begin
        q   = r_c_ymag[32:24];
        rem = r_c_ymag[23:0];
        if (!r_c_neg) begin
            n_n = 11'(q);
            n_f = rem;
        end else if (rem == '0) begin
            n_n = -11'(q);
            n_f = '0;
        end else begin
            n_n = -11'(q) - 11'sd1;
            n_f = 24'(25'h1000000 - 25'(rem));
        end
    end

    // cubic polynomial terms
    assign rmul  = 54'(r_d_f) * 54'(LN2_Q30);
    assign a2mul = 44'(r_e_a) * 44'(r_e_a);
    assign a3mul = 36'(r_f_a2) * 36'(r_f_a);
    assign a3div = 12'(r_g_a3) * 12'(RECIP6);
    assign n_m   = ONE_Q30 + 32'(r_g_a) + 32'(r_g_a2 >> 1) + 32'(a3div >> 8);

    // early stages through the polynomial
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_z      <= i_sample;
            r_b_x      <= 32'(i_cfg.spread) * 32'(zmag);
            r_b_neg    <= r_a_z[15];
            r_c_ymag   <= ymul[62:30];
            r_c_neg    <= r_b_neg;
            r_n[ST_D]  <= n_n;
            r_d_f      <= n_f;
            r_e_a      <= rmul[53:32];
            r_f_a      <= r_e_a;
            r_f_a2     <= a2mul[43:30];
            r_g_a      <= r_f_a;
            r_g_a2     <= r_f_a2;
            r_g_a3     <= a3mul[35:30];
            r_h_m      <= n_m;
        end
    end

    // integer exponent rides alongside the fraction
    for (genvar i = ST_D + 1; i <= ST_P; i++) begin : g_n
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_n[i] <= r_n[i-1];
            end
        end
    end

    // eight squaring stages
    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        logic [31:0] sq_in;
        logic [63:0] sq_prod;
        if (k == 0) begin : g_first
            assign sq_in = r_h_m;
        end else begin : g_rest
            assign sq_in = r_sq[k-1];
        end
        assign sq_prod = 64'(sq_in) * 64'(sq_in);
        always_ff @(posedge i_clk) begin
            if (en) begin
                r_sq[k] <= sq_prod[61:30];
            end
        end
    end

    // scale by exponent and saturate to 32 bits
    always_comb begin
        logic signed [11:0] sh;
        logic [7:0]         k;
        logic [63:0]        p;
        sh      = 12'sd30 - 12'(r_n[ST_P]);
        k       = 8'(-sh);
        p       = '0;
        n_price = '0;
        if (r_p_prod == '0) begin
            n_price = '0;
        end else if (sh >= 0) begin
            if (sh >= 12'sd64) begin
                n_price = '0;
            end else begin
                p       = r_p_prod >> sh[5:0];
                n_price = (p[63:32] != '0) ? '1 : p[31:0];
            end
        end else if (k > 8'd32) begin
            n_price = '1;
        end else if (r_p_prod > (64'hFFFFFFFF >> k)) begin
            n_price = '1;
        end else begin
            p       = r_p_prod << k;
            n_price = p[31:0];
        end
    end

    // price product, price and payoff stages
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_p_prod  <= 64'(i_cfg.growth) * 64'(r_sq[SQ_STEPS-1]);
            r_q_price <= n_price;
            r_r_pay   <= (r_q_price > i_cfg.strike) ? r_q_price - i_cfg.strike : '0;
        end
    end

    // saturating sum and count, full count ignores samples
    always_comb begin
        sum_ext = {1'b0, r_sum} + (SUM_BITS+1)'(r_r_pay);
        n_sum   = r_sum;
        n_count = r_count;
        if (r_count != '1) begin
            n_sum   = sum_ext[SUM_BITS] ? '1 : sum_ext[SUM_BITS-1:0];
            n_count = r_count + 1'b1;
        end
    end

    assign o_push      = r_vld[NSTG-1] && r_last[NSTG-1] && en;
    assign o_run.sum   = n_sum;
    assign o_run.count = n_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum   <= '0;
            r_count <= '0;
        end else if (r_vld[NSTG-1] && en) begin
            if (r_last[NSTG-1]) begin
                r_sum   <= '0;
                r_count <= '0;
            end else begin
                r_sum   <= n_sum;
                r_count <= n_count;
            end
        end
    end

endmodule

FILE: hw/rtl/mcpa_fifo.sv
// short queue of finished runs between front and back
`include "monte_carlo_call_payoff_accumulator_defines.svh"
module mcpa_fifo (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  mcpa_pkg::t_run i_run,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_valid,
    output mcpa_pkg::t_run o_run
);
    import mcpa_pkg::*;

    localparam int PW = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
    localparam int CW = $clog2(Q_DEPTH + 1);

    t_run          r_mem [Q_DEPTH];
    logic [PW-1:0] r_wr;
    logic [PW-1:0] r_rd;
    logic [CW-1:0] r_cnt;

    assign o_full  = (r_cnt == CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_run   = r_mem[r_rd];

    // storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_run;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            r_cnt <= r_cnt + CW'(i_push) - CW'(i_pop);
        end
    end

    `MCPA_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, o_full, !i_push, "push into full queue")
    `MCPA_ASSERT_NOW(a_no_underflow, i_clk, i_rst_n, !o_valid, !i_pop, "pop from empty queue")
    `MCPA_ASSERT_NEXT(a_push_seen, i_clk, i_rst_n, i_push && !i_pop, o_valid, "push lost")

endmodule

FILE: hw/rtl/mcpa_back.sv
// back: mean by restoring division, discounting and output register
`include "monte_carlo_call_payoff_accumulator_defines.svh"
module mcpa_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic [16:0]    i_discount,
    input  logic           i_q_valid,
    input  mcpa_pkg::t_run i_run,
    output logic           o_pop,
    output logic           o_valid,
    input  logic           i_ready,
    output logic [31:0]    o_price,
    output logic [31:0]    o_count
);
    import mcpa_pkg::*;

    localparam int SW = $clog2(DIV_STEPS);

    t_back_state           r_state;
    t_back_state           n_state;
    logic [COUNT_BITS-1:0] r_rem;
    logic [SUM_BITS-1:0]   r_quo;
    logic [COUNT_BITS-1:0] r_div;
    logic                  r_zero;
    logic [SW-1:0]         r_step;
    logic [48:0]           r_prod;
    logic                  r_out_valid;
    logic [31:0]           r_out_price;
    logic [31:0]           r_out_count;

    logic                  out_free;
    logic                  step_last;
    logic [COUNT_BITS:0]   rem_sh;
    logic                  ge;
    logic [31:0]           mean;

    assign out_free  = !r_out_valid || i_ready;
    assign step_last = (r_step == SW'(DIV_STEPS - 1));
    assign rem_sh    = {r_rem, r_quo[SUM_BITS-1]};
    assign ge        = (rem_sh >= {1'b0, r_div});
    assign mean      = r_zero ? '0 :
                       ((r_quo[SUM_BITS-1:32] != '0) ? '1 : r_quo[31:0]);

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE:  if (i_q_valid) n_state = BK_DIV;
            BK_DIV:   if (step_last) n_state = BK_SCALE;
            BK_SCALE: n_state = BK_HOLD;
            BK_HOLD:  if (out_free) n_state = BK_IDLE;
            default:  n_state = BK_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        o_pop = 1'b0;
        case (r_state)
            BK_IDLE: o_pop = i_q_valid;
            default: o_pop = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // division datapath, one quotient bit a cycle
    always_ff @(posedge i_clk) begin
        case (r_state)
            BK_IDLE: begin
                r_rem  <= '0;
                r_quo  <= i_run.sum;
                r_div  <= i_run.count;
                r_zero <= (i_run.count == '0);
                r_step <= '0;
            end
            BK_DIV: begin
                r_rem  <= ge ? COUNT_BITS'(rem_sh - {1'b0, r_div}) : COUNT_BITS'(rem_sh);
                r_quo  <= {r_quo[SUM_BITS-2:0], ge};
                r_step <= r_step + 1'b1;
            end
            BK_SCALE: begin
                r_prod <= 49'(mean) * 49'(i_discount);
            end
            default: begin
                r_step <= r_step;
            end
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (r_state == BK_HOLD && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == BK_HOLD && out_free) begin
            r_out_price <= r_prod[48] ? '1 : r_prod[47:16];
            r_out_count <= 32'(r_div);
        end
    end

    assign o_valid = r_out_valid;
    assign o_price = r_out_price;
    assign o_count = r_out_count;

    `MCPA_ASSERT_NOW(a_pop_idle, i_clk, i_rst_n, o_pop, r_state == BK_IDLE, "pop outside idle")
    `MCPA_ASSERT_NEXT(a_div_end, i_clk, i_rst_n, r_state == BK_DIV && step_last, r_state == BK_SCALE, "division overran")
    `MCPA_ASSERT_NEXT(a_start, i_clk, i_rst_n, o_pop, r_state == BK_DIV && r_step == '0, "run not started")

endmodule

FILE: hw/rtl/monte_carlo_call_payoff_accumulator.sv
// top level of the call payoff accumulator
// Usage:
// Samples enter on the s_axis channel, one word per normal draw (signed Q4.12
// in tdata[15:0]); tlast closes a run. Each sample is priced in a 19-stage
// pipeline and its payoff is summed; one sample per cycle is sustained while the queue has room.
// When a run closes, the sum and count move through a two-entry queue to a
// restoring divider that makes one quotient bit per cycle; the back end takes
// one run at a time, and the discounted price leaves on
// m_axis (price in tdata[31:0], sample count in tdata[63:32]).
// Runs closing faster than the back end finishes them fill the queue and
// then stall s_axis through s_axis_tready.
// A stalled m_axis receiver holds the output word; the back end finishes the
// next run and waits, then the queue fills and the front stops.
// Synchronous reset clears the pipeline valid flags, the sum, the count and the queue
// and loads the default registers. Registers are written through i_cfg_we; the user
// must write them only while the block is idle, which the block itself does not enforce.
module monte_carlo_call_payoff_accumulator (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // [15:0] normal_sample
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // [31:0] option_price, [63:32] samples_used
);
    import mcpa_pkg::*;

    logic [31:0] r_growth;
    logic [15:0] r_spread;
    logic [31:0] r_strike;
    logic [16:0] r_discount;

    t_front_cfg  front_cfg;
    t_run        push_run;
    t_run        head_run;
    logic        push;
    logic        pop;
    logic        q_full;
    logic        q_valid;
    logic [31:0] price;
    logic [31:0] count;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_growth   <= 32'd65536;
            r_spread   <= 16'd4096;
            r_strike   <= 32'd65536;
            r_discount <= 17'd65536;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_GROWTH:   r_growth   <= i_cfg_wdata;
                REG_SPREAD:   r_spread   <= i_cfg_wdata[15:0];
                REG_STRIKE:   r_strike   <= i_cfg_wdata;
                REG_DISCOUNT: r_discount <= i_cfg_wdata[16:0];
                default:      r_growth   <= r_growth;
            endcase
        end
    end

    assign front_cfg.growth = r_growth;
    assign front_cfg.spread = r_spread;
    assign front_cfg.strike = r_strike;

    mcpa_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (front_cfg),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_sample (s_axis_tdata),
        .i_last   (s_axis_tlast),
        .i_q_full (q_full),
        .o_push   (push),
        .o_run    (push_run)
    );

    mcpa_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_run   (push_run),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_run   (head_run)
    );

    mcpa_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_discount (r_discount),
        .i_q_valid  (q_valid),
        .i_run      (head_run),
        .o_pop      (pop),
        .o_valid    (m_axis_tvalid),
        .i_ready    (m_axis_tready),
        .o_price    (price),
        .o_count    (count)
    );

    assign m_axis_tdata = {count, price};

endmodule

FILE: tb/sv/mcpa_checker.sv
// checker for the call payoff accumulator: predicts run prices and compares
module mcpa_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,
    input  logic        i_s_tlast,
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [63:0] i_m_tdata,
    output int          o_fail_count,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import mcpa_pkg::*;

    localparam logic [63:0] LOG2E = 64'd1549082005;
    localparam logic [63:0] LN2   = 64'd744261118;
    localparam logic [63:0] U32M  = 64'hFFFF_FFFF;

    logic [31:0] growth_r;
    logic [15:0] spread_r;
    logic [31:0] strike_r;
    logic [16:0] disc_r;
    logic [63:0] sum_r;
    logic [63:0] count_r;
    logic [63:0] price_q[$];
    int          fails;

    assign o_fail_count = fails;
    assign o_pending    = price_q.size();

    // 2^f for a 24-bit fraction, Q30
    function automatic logic [63:0] pow2_frac(input logic [63:0] f);
        logic [63:0] r, a, a2, a3, m;
        r  = ((f & 64'hFFFFFF) * LN2) >> 24;
        a  = r >> 8;
        a2 = (a * a) >> 30;
        a3 = (a2 * a) >> 30;
        m  = (64'd1 << 30) + a + (a2 >> 1) + a3 / 6;
        for (int i = 0; i < 8; i++) m = (m * m) >> 30;
        return m;
    endfunction

    // terminal price for one draw, saturated to 32 bits
    function automatic logic [63:0] spot_at_expiry(input logic [15:0] z);
        logic        neg;
        logic [63:0] zmag, ymag, q, rem, f, prod, p;
        longint      n, sh;
        neg  = z[15];
        zmag = neg ? (64'h10000 - z) : {48'd0, z};
        ymag = ((spread_r * zmag) * LOG2E) >> 30;
        q    = ymag >> 24;
        rem  = ymag & 64'hFFFFFF;
        if (!neg) begin
            n = q; f = rem;
        end else if (rem == 0) begin
            n = -longint'(q); f = 0;
        end else begin
            n = -longint'(q) - 1; f = (64'd1 << 24) - rem;
        end
        prod = growth_r * pow2_frac(f);
        if (prod == 0) return 0;
        sh = 30 - n;
        if (sh >= 0) begin
            p = (sh >= 64) ? 0 : (prod >> sh);
            return (p > U32M) ? U32M : p;
        end
        if (-sh > 32) return U32M;
        if (prod > (U32M >> (-sh))) return U32M;
        return prod << (-sh);
    endfunction

    // track registers, accumulate payoffs, compare output words
    always @(posedge i_clk) begin
        logic [63:0] p, pay, s, mean, pr, exp_w;
        if (!i_rst_n) begin
            growth_r = 32'd65536; spread_r = 16'd4096;
            strike_r = 32'd65536; disc_r = 17'd65536;
            sum_r = 0; count_r = 0;
            price_q.delete();
            fails = 0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_GROWTH:   growth_r = i_cfg_wdata;
                    REG_SPREAD:   spread_r = i_cfg_wdata[15:0];
                    REG_STRIKE:   strike_r = i_cfg_wdata;
                    REG_DISCOUNT: disc_r = i_cfg_wdata[16:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                if (price_q.size() == 0) begin
                    $display("%0t: unexpected word %h", $realtime, i_m_tdata);
                    fails++;
                end else begin
                    exp_w = price_q.pop_front();
                    if (exp_w[31:0] !== i_m_tdata[31:0]) begin
                        $display("%0t: price expected %h actual %h", $realtime,
                                 exp_w[31:0], i_m_tdata[31:0]);
                        fails++;
                    end
                    if (exp_w[63:32] !== i_m_tdata[63:32]) begin
                        $display("%0t: count expected %h actual %h", $realtime,
                                 exp_w[63:32], i_m_tdata[63:32]);
                        fails++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (count_r < ((64'd1 << COUNT_BITS) - 1)) begin
                    p   = spot_at_expiry(i_s_tdata);
                    pay = (p > strike_r) ? p - strike_r : 0;
                    s   = sum_r + pay;
                    sum_r = (s < sum_r) ? 64'hFFFF_FFFF_FFFF_FFFF : s;
                    count_r++;
                end
                if (i_s_tlast) begin
                    if (count_r == 0) pr = 0;
                    else begin
                        mean = sum_r / count_r;
                        if (mean > U32M) mean = U32M;
                        pr = (mean * disc_r) >> 16;
                        if (pr > U32M) pr = U32M;
                    end
                    exp_w = {count_r[31:0], pr[31:0]};
                    price_q.insert(price_q.size(), exp_w);
                    sum_r = 0; count_r = 0;
                end
            end
        end
    end
endmodule

FILE: tb/sv/tb_monte_carlo_call_payoff_accumulator.sv
// stimulus and verdict for the call payoff accumulator
module tb_monte_carlo_call_payoff_accumulator;
    timeunit 1ns;
    timeprecision 1ps;
    import mcpa_pkg::*;

    logic        i_clk = 0, i_rst_n = 0;
    logic        i_cfg_we = 0;
    logic [1:0]  i_cfg_addr = REG_GROWTH;
    logic [31:0] i_cfg_wdata = 0;
    logic        s_axis_tvalid = 0, s_axis_tlast = 0, m_axis_tready = 0;
    logic [15:0] s_axis_tdata = 0;
    logic        s_axis_tready, m_axis_tvalid;
    logic [63:0] m_axis_tdata;
    int          fail_count, pending;
    int          send_idle = 0, recv_idle = 0;
    int          hold_off = 0;
    longint      cycles = 0;

    monte_carlo_call_payoff_accumulator uut (.*);

    mcpa_checker chk (
        .i_clk, .i_rst_n, .i_cfg_we, .i_cfg_addr, .i_cfg_wdata,
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready),
        .i_s_tdata(s_axis_tdata), .i_s_tlast(s_axis_tlast),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready),
        .i_m_tdata(m_axis_tdata), .o_fail_count(fail_count), .o_pending(pending)
    );

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    // receiver: random stalls plus an optional long hold-off
    always @(posedge i_clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
        end
    end

    // run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > 400000) begin
            $display("monte_carlo_call_payoff_accumulator verification failed");
            $finish;
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        i_cfg_we <= 1'b1; i_cfg_addr <= idx; i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    // send one sample word, honoring the sender idle rate
    task automatic send_sample(input logic [15:0] z, input logic last);
        while ($urandom_range(99) < send_idle) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1; s_axis_tdata <= z; s_axis_tlast <= last;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain_idle();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (120) @(posedge i_clk);
    endtask

    // random z, mostly mild values with occasional extremes
    function automatic logic [15:0] rand_z();
        if ($urandom_range(9) == 0) return 16'($urandom);
        return 16'($signed($urandom_range(16384)) - 8192);
    endfunction

    task automatic random_runs(input int n);
        int len;
        while (n > 0) begin
            len = ($urandom_range(7) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
            for (int k = 0; k < len && n > 0; k++) begin
                n--;
                send_sample(rand_z(), (k == len - 1) || (n == 0));
            end
        end
    endtask

    initial begin
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: field extremes with reset registers
        send_sample(16'h0000, 1'b1);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h8001, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h1000, 1'b1);
        send_sample(16'hF000, 1'b1);
        drain_idle();

        // saturated prices and discount above one
        write_reg(REG_GROWTH, 32'hFFFF_FFFF);
        write_reg(REG_SPREAD, 16'hFFFF);
        write_reg(REG_STRIKE, 32'd0);
        write_reg(REG_DISCOUNT, 32'h1FFFF);
        for (int k = 0; k < 6; k++) send_sample(16'h7FFF, k == 5);
        send_sample(16'h8000, 1'b1);
        send_sample(16'h0001, 1'b1);
        drain_idle();

        // zero growth and zero spread, huge strike
        write_reg(REG_GROWTH, 32'd0);
        write_reg(REG_SPREAD, 16'd0);
        write_reg(REG_STRIKE, 32'hFFFF_FFFF);
        write_reg(REG_DISCOUNT, 32'd0);
        send_sample(16'h7FFF, 1'b1);
        send_sample(16'h1234, 1'b1);
        drain_idle();

        // phase 1: sender idles often, receiver mostly stalls
        write_reg(REG_GROWTH, 32'd6553600);
        write_reg(REG_SPREAD, 16'd819);
        write_reg(REG_STRIKE, 32'd6553600);
        write_reg(REG_DISCOUNT, 32'd62000);
        send_idle = 35; recv_idle = 80;
        random_runs(130);
        drain_idle();

        // long receiver hold-off while short runs back up the queue
        hold_off = 600;
        send_idle = 0; recv_idle = 0;
        for (int k = 0; k < 20; k++) send_sample(rand_z(), 1'b1);
        drain_idle();

        // phase 2: swapped idling with random registers
        write_reg(REG_GROWTH, $urandom);
        write_reg(REG_SPREAD, $urandom_range(65535));
        write_reg(REG_STRIKE, $urandom);
        write_reg(REG_DISCOUNT, $urandom_range(65536));
        send_idle = 80; recv_idle = 35;
        random_runs(130);
        drain_idle();

        // phase 3: no idling, typical option
        write_reg(REG_GROWTH, 32'd6700000);
        write_reg(REG_SPREAD, 16'd1200);
        write_reg(REG_STRIKE, 32'd6500000);
        write_reg(REG_DISCOUNT, 32'd65536);
        send_idle = 0; recv_idle = 0;
        random_runs(130);
        drain_idle();

        if (fail_count == 0)
            $display("monte_carlo_call_payoff_accumulator verification clean");
        else
            $display("monte_carlo_call_payoff_accumulator verification failed");
        $finish;
    end
endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/mcpa_pkg.sv
hw/rtl/mcpa_front.sv
hw/rtl/mcpa_fifo.sv
hw/rtl/mcpa_back.sv
hw/rtl/monte_carlo_call_payoff_accumulator.sv
tb/sv/mcpa_checker.sv
tb/sv/tb_monte_carlo_call_payoff_accumulator.sv
